// File: sv/utv_pkg.sv
`default_nettype none

package utv_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH = 2'd1;

  localparam logic [7:0] MIN_LENGTH_RST = 8'd1;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd32;

  // UTF-8 lead byte ranges and code point limits.
  localparam logic [7:0] ASCII_LAST = 8'h7f;
  localparam logic [7:0] LEAD2_FIRST = 8'hc2;
  localparam logic [7:0] LEAD2_LAST = 8'hdf;
  localparam logic [7:0] LEAD3_FIRST = 8'he0;
  localparam logic [7:0] LEAD3_LAST = 8'hef;
  localparam logic [7:0] LEAD4_FIRST = 8'hf0;
  localparam logic [7:0] LEAD4_LAST = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG = 8'h80;

  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] CP_MAX = 21'h10ffff;
  localparam logic [CpW-1:0] SURR_FIRST = 21'h00d800;
  localparam logic [CpW-1:0] SURR_LAST = 21'h00dfff;
  localparam logic [CpW-1:0] CLASS2_MIN = 21'h000080;
  localparam logic [CpW-1:0] CLASS3_MIN = 21'h000800;
  localparam logic [CpW-1:0] CLASS4_MIN = 21'h010000;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_TWO = 2'd1;
  localparam logic [1:0] CLASS_THREE = 2'd2;
  localparam logic [1:0] CLASS_FOUR = 2'd3;

  typedef struct packed {
    logic [1:0]     pending;
    logic [CpW-1:0] cp_acc;
    logic [1:0]     seq_class;
    logic           failed;
  } dec_state_t;

endpackage

`default_nettype wire

// File: sv/utf8_text_validator_unit.sv
`default_nettype none

// A string's verdict is offered from the result register once its final byte leaves the input register.
// Throughput: one byte per cycle while the result register can take each final byte; the
// input register feeds the decoder and length check, whose verdict lands in the result register.
// Reset clears the string state, all valid flags, and sets min_length to 1, max_length to 32.
module utf8_text_validator_unit #(
  parameter int unsigned MAX_TEXT_BYTES = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          final_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          text_ok_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import utv_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       final_q;
  logic       out_valid_q, out_valid_d;
  logic       text_ok_q;
  logic [7:0] min_length_q, max_length_q;
  logic       res_free, advance, verdict;

  assign res_free   = !out_valid_q || !out_stall_i;
  // Bytes that end no string never need the result register.
  assign advance    = in_valid_q && (!final_q || res_free);
  assign in_stall_o = in_valid_q && !advance;

  assign cfg_ready_o = 1'b1;

  utv_tracker #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (byte_q),
    .final_i      (final_q),
    .min_length_i (min_length_q),
    .max_length_i (max_length_q),
    .verdict_o    (verdict)
  );

  assign in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
  assign out_valid_d = (advance && final_q) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      min_length_q <= MIN_LENGTH_RST;
      max_length_q <= MAX_LENGTH_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MIN_LENGTH: min_length_q <= cfg_data_i;
          CFG_MAX_LENGTH: max_length_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q  <= text_byte_i;
      final_q <= final_byte_i;
    end
    if (advance && final_q) begin
      text_ok_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_ok_o   = text_ok_q;

endmodule

`default_nettype wire

// File: sv/utv_decode.sv
`default_nettype none

module utv_decode (
  input  utv_pkg::dec_state_t state_i,
  input  logic [7:0]          byte_i,
  output utv_pkg::dec_state_t state_o
);
  import utv_pkg::*;

  logic [CpW-1:0] cp_shift;
  logic [1:0]     pending_dec;
  logic [CpW-1:0] class_min;
  logic           cp_bad;

  assign cp_shift = {state_i.cp_acc[CpW-7:0], byte_i[5:0]};
  assign pending_dec = state_i.pending - 2'd1;

  always_comb begin
    unique case (state_i.seq_class)
      CLASS_TWO:   class_min = CLASS2_MIN;
      CLASS_THREE: class_min = CLASS3_MIN;
      default:     class_min = CLASS4_MIN;
    endcase
  end

  assign cp_bad = (cp_shift < class_min) || (cp_shift > CP_MAX) ||
                  ((cp_shift >= SURR_FIRST) && (cp_shift <= SURR_LAST));

  always_comb begin
    state_o = state_i;
    if (byte_i == 8'd0) begin
      state_o.failed = 1'b1;
    end
    if (state_i.pending == 2'd0) begin
      priority if (byte_i <= ASCII_LAST) begin
        state_o.pending = 2'd0;
      end else if (byte_i >= LEAD2_FIRST && byte_i <= LEAD2_LAST) begin
        state_o.cp_acc    = {{(CpW-5){1'b0}}, byte_i[4:0]};
        state_o.pending   = 2'd1;
        state_o.seq_class = CLASS_TWO;
      end else if (byte_i >= LEAD3_FIRST && byte_i <= LEAD3_LAST) begin
        state_o.cp_acc    = {{(CpW-4){1'b0}}, byte_i[3:0]};
        state_o.pending   = 2'd2;
        state_o.seq_class = CLASS_THREE;
      end else if (byte_i >= LEAD4_FIRST && byte_i <= LEAD4_LAST) begin
        state_o.cp_acc    = {{(CpW-3){1'b0}}, byte_i[2:0]};
        state_o.pending   = 2'd3;
        state_o.seq_class = CLASS_FOUR;
      end else begin
        state_o.failed = 1'b1;
      end
    end else if ((byte_i & CONT_MASK) != CONT_TAG) begin
      // A missing continuation byte closes the open sequence.
      state_o.failed    = 1'b1;
      state_o.pending   = 2'd0;
      state_o.cp_acc    = '0;
      state_o.seq_class = CLASS_NONE;
    end else if (pending_dec == 2'd0) begin
      if (cp_bad) begin
        state_o.failed = 1'b1;
      end
      state_o.pending   = 2'd0;
      state_o.cp_acc    = '0;
      state_o.seq_class = CLASS_NONE;
    end else begin
      state_o.cp_acc  = cp_shift;
      state_o.pending = pending_dec;
    end
  end

endmodule

`default_nettype wire

// File: sv/utv_tracker.sv
`default_nettype none

module utv_tracker #(
  parameter int unsigned MAX_TEXT_BYTES = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  input  logic [7:0] min_length_i,
  input  logic [7:0] max_length_i,
  output logic       verdict_o
);
  import utv_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TEXT_BYTES + 2);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;
  localparam logic [CntW-1:0] CntLimit = CntW'(MAX_TEXT_BYTES);

  logic [CntW-1:0] count_q, count_d, count_inc;
  dec_state_t      dec_q, dec_d, dec_next;
  logic [CmpW-1:0] count_cmp, min_cmp, max_cmp;
  logic            length_ok;

  utv_decode u_decode (
    .state_i (dec_q),
    .byte_i  (byte_i),
    .state_o (dec_next)
  );

  // The count stops one past the limit, so any longer string stays too long.
  assign count_inc = (count_q <= CntLimit) ? count_q + CntW'(1) : count_q;

  assign count_cmp = CmpW'(count_inc);
  assign min_cmp   = CmpW'(min_length_i);
  assign max_cmp   = CmpW'(max_length_i);
  assign length_ok = (count_cmp >= min_cmp) && (count_cmp <= max_cmp) &&
                     (count_inc <= CntLimit);

  assign verdict_o = !dec_next.failed && (dec_next.pending == 2'd0) && length_ok;

  always_comb begin
    count_d = count_q;
    dec_d   = dec_q;
    if (step_i) begin
      if (final_i) begin
        count_d = '0;
        dec_d   = '0;
      end else begin
        count_d = count_inc;
        dec_d   = dec_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dec_q   <= '0;
    end else begin
      count_q <= count_d;
      dec_q   <= dec_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/utf8_text_validator_unit_tb.sv
`default_nettype none

module utf8_text_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utv_pkg::*;

  localparam int unsigned MaxTextBytes = 255;
  localparam int unsigned CycleLimit = 200_000;

  typedef logic [7:0] text_q_t[$];

  typedef enum int unsigned {
    FLIP_BYTE,
    CUT_OFF,
    OVERLONG,
    SURROGATE,
    TOO_BIG,
    ZERO_BYTE,
    STRAY_CONT
  } fault_e;

  // Opening checks: each entry is {final flag, byte}.
  localparam logic [8:0] OpeningBytes[24] = '{
    9'h141,                          // single ASCII byte
    9'h100,                          // zero byte
    9'h17f,                          // highest ASCII byte
    9'h1ff,                          // byte that can never lead
    9'h0c2, 9'h180,                  // smallest two-byte form
    9'h0e0, 9'h080, 9'h180,          // overlong three-byte form
    9'h0ed, 9'h0a0, 9'h180,          // surrogate
    9'h0f4, 9'h08f, 9'h0bf, 9'h1bf,  // highest code point
    9'h0f4, 9'h090, 9'h080, 9'h180,  // above the highest code point
    9'h0c2, 9'h141,                  // bad continuation
    9'h0e2, 9'h182                   // sequence cut off by the final byte
  };

  class verdict_board;
    logic [7:0]     min_len;
    logic [7:0]     max_len;
    logic [8:0]     count;
    logic [1:0]     pending;
    logic [CpW-1:0] cp_acc;
    logic [1:0]     seq_class;
    bit             failed;
    bit             verdicts[$];
    int unsigned    errors;

    function new();
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      count = '0;
      pending = '0;
      cp_acc = '0;
      seq_class = CLASS_NONE;
      failed = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_MIN_LENGTH: min_len = data;
        CFG_MAX_LENGTH: max_len = data;
        default: ;
      endcase
    endfunction

    function logic [CpW-1:0] class_floor(logic [1:0] cls);
      case (cls)
        CLASS_TWO:   return CLASS2_MIN;
        CLASS_THREE: return CLASS3_MIN;
        default:     return CLASS4_MIN;
      endcase
    endfunction

    function void decode(logic [7:0] b);
      if (pending == 2'd0) begin
        if (b <= ASCII_LAST) begin
          return;
        end else if (b >= LEAD2_FIRST && b <= LEAD2_LAST) begin
          cp_acc = CpW'(b[4:0]);
          pending = 2'd1;
          seq_class = CLASS_TWO;
        end else if (b >= LEAD3_FIRST && b <= LEAD3_LAST) begin
          cp_acc = CpW'(b[3:0]);
          pending = 2'd2;
          seq_class = CLASS_THREE;
        end else if (b >= LEAD4_FIRST && b <= LEAD4_LAST) begin
          cp_acc = CpW'(b[2:0]);
          pending = 2'd3;
          seq_class = CLASS_FOUR;
        end else begin
          failed = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        // A broken sequence is abandoned; the string has already failed.
        failed = 1'b1;
        pending = '0;
        cp_acc = '0;
        seq_class = CLASS_NONE;
      end else begin
        cp_acc = {cp_acc[CpW-7:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending == 2'd0) begin
          if (cp_acc < class_floor(seq_class) || cp_acc > CP_MAX ||
              (cp_acc >= SURR_FIRST && cp_acc <= SURR_LAST)) begin
            failed = 1'b1;
          end
          cp_acc = '0;
          seq_class = CLASS_NONE;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (count <= MaxTextBytes) count = count + 9'd1;
      if (b == 8'h00) failed = 1'b1;
      decode(b);
      if (last) begin
        verdicts.push_back(!failed && pending == 2'd0 && count >= min_len &&
                           count <= max_len && count <= MaxTextBytes);
        clear_text();
      end
    endfunction

    function int unsigned pending_verdicts();
      return verdicts.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(logic ok);
      bit want;
      if (verdicts.size() == 0) begin
        report($sformatf("verdict %b with none expected", ok));
        return;
      end
      want = verdicts.pop_front();
      if (ok !== want) report($sformatf("text_ok %b, expected %b", ok, want));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          text_byte_i;
  logic                final_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                text_ok_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [7:0]          cfg_data_i;

  verdict_board sb = new();
  bit           idle_on = 1'b1;
  int unsigned  cycles = 0;

  utf8_text_validator_unit #(
    .MAX_TEXT_BYTES(MaxTextBytes)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_ok_o   (text_ok_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(text_ok_o);
  end

  // Result side stalls in bursts while idling is enabled.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && hold == 0 && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 16);
      out_stall_i = (hold != 0);
      if (hold != 0) hold--;
    end
  end

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic void put_code_point(ref text_q_t q, input logic [CpW-1:0] cp);
    if (cp < 'h80) begin
      q.push_back(cp[7:0]);
    end else if (cp < 'h800) begin
      q.push_back({3'b110, cp[10:6]});
      q.push_back({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      q.push_back({4'b1110, cp[15:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end else begin
      q.push_back({5'b11110, cp[20:18]});
      q.push_back({2'b10, cp[17:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [CpW-1:0] rand_code_point();
    logic [CpW-1:0] cp;
    case ($urandom_range(0, 3))
      0: cp = CpW'($urandom_range(1, 'h7f));
      1: cp = CpW'($urandom_range('h80, 'h7ff));
      2: begin
        do cp = CpW'($urandom_range('h800, 'hffff));
        while (cp >= SURR_FIRST && cp <= SURR_LAST);
      end
      default: cp = CpW'($urandom_range('h10000, 'h10ffff));
    endcase
    return cp;
  endfunction

  // Builds a well-formed string of exactly len bytes, then optionally breaks it once.
  function automatic void make_text(ref text_q_t q, input int unsigned len, input bit broken);
    logic [CpW-1:0] cp;
    int unsigned    n;
    int unsigned    pos;
    fault_e         fault;
    text_q_t        bad;
    q.delete();
    while (q.size() < len) begin
      cp = rand_code_point();
      n = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
      if (q.size() + n > len) cp = CpW'($urandom_range(1, 'h7f));
      put_code_point(q, cp);
    end
    if (!broken) return;
    fault = fault_e'($urandom_range(0, 6));
    pos = $urandom_range(0, q.size());
    case (fault)
      FLIP_BYTE: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      CUT_OFF: begin
        pos = q.size();
        case ($urandom_range(0, 2))
          0: bad = '{8'($urandom_range('hc2, 'hdf))};
          1: bad = '{8'($urandom_range('he1, 'hec)), cont_byte()};
          default: bad = '{8'($urandom_range('hf1, 'hf3)), cont_byte(), cont_byte()};
        endcase
      end
      OVERLONG: begin
        case ($urandom_range(0, 2))
          0: bad = '{8'($urandom_range('hc0, 'hc1)), cont_byte()};
          1: bad = '{8'he0, 8'($urandom_range('h80, 'h9f)), cont_byte()};
          default: bad = '{8'hf0, 8'($urandom_range('h80, 'h8f)), cont_byte(), cont_byte()};
        endcase
      end
      SURROGATE: bad = '{8'hed, 8'($urandom_range('ha0, 'hbf)), cont_byte()};
      TOO_BIG: begin
        if ($urandom_range(0, 1) == 0) begin
          bad = '{8'hf4, 8'($urandom_range('h90, 'hbf)), cont_byte(), cont_byte()};
        end else begin
          bad = '{8'($urandom_range('hf5, 'hff))};
        end
      end
      ZERO_BYTE: bad = '{8'h00};
      default: bad = '{cont_byte()};
    endcase
    foreach (bad[i]) q.insert(pos + i, bad[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(logic [7:0] b, logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    text_byte_i = b;
    final_byte_i = last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_text(text_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic text_burst(int unsigned budget, int unsigned max_len);
    int unsigned sent;
    text_q_t     q;
    sent = 0;
    while (sent < budget) begin
      make_text(q, $urandom_range(1, max_len), $urandom_range(0, 9) < 3);
      send_text(q);
      sent += q.size();
    end
  endtask

  // Lets every outstanding verdict arrive, then lets the pipeline settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_verdicts() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    text_q_t q;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    text_byte_i = '0;
    final_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (OpeningBytes[i]) send_byte(OpeningBytes[i][7:0], OpeningBytes[i][8]);
    drain();

    // A minimum of zero acts like one; the widest window.
    cfg_write(CFG_MIN_LENGTH, 8'd0);
    cfg_write(CFG_MAX_LENGTH, 8'd255);
    text_burst(100, 40);
    drain();

    // Narrow window; writes beyond the register list must be ignored.
    cfg_write(CFG_MIN_LENGTH, 8'd3);
    cfg_write(CFG_MAX_LENGTH, 8'd6);
    for (int i = int'(CFG_MAX_LENGTH) + 1; i < (1 << CfgIdxW); i++) begin
      cfg_write(CfgIdxW'(i), 8'($urandom_range(0, 255)));
    end
    text_burst(90, 9);
    drain();

    // Minimum above maximum: nothing can pass.
    cfg_write(CFG_MIN_LENGTH, 8'd200);
    cfg_write(CFG_MAX_LENGTH, 8'd0);
    text_burst(50, 10);
    drain();

    // Longest legal string, then one that runs the byte counter into saturation.
    cfg_write(CFG_MIN_LENGTH, 8'd255);
    cfg_write(CFG_MAX_LENGTH, 8'd255);
    make_text(q, 255, 1'b0);
    send_text(q);
    make_text(q, 257, 1'b0);
    send_text(q);
    drain();

    // Back to the reset window, with no idling on either side.
    cfg_write(CFG_MIN_LENGTH, MIN_LENGTH_RST);
    cfg_write(CFG_MAX_LENGTH, MAX_LENGTH_RST);
    idle_on = 1'b0;
    text_burst(80, 36);
    drain();
    repeat (8) @(negedge clk_i);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/utv_pkg.sv
sv/utv_decode.sv
sv/utv_tracker.sv
sv/utf8_text_validator_unit.sv
tb/sv/utf8_text_validator_unit_tb.sv
